FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the gesture detector checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define BGD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`endif

FILE: src/bgd_pkg.sv
// ---------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture detector
// ---------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE_TICKS     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_MULTI_PRESS_WINDOW = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_RESTART_HOLD_TICKS = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_FACTORY_HOLD_TICKS = 2'd3;

  localparam logic [7:0]  DEBOUNCE_TICKS_RESET     = 8'd50;
  localparam logic [15:0] MULTI_PRESS_WINDOW_RESET = 16'd1000;
  localparam logic [15:0] RESTART_HOLD_TICKS_RESET = 16'd5000;
  localparam logic [15:0] FACTORY_HOLD_TICKS_RESET = 16'd10000;

  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  localparam logic [7:0]  QUIET_MAX = 8'hff;
  localparam logic [15:0] TIMER_MAX = 16'hffff;
  localparam logic [7:0]  COUNT_MAX = 8'hff;

  typedef struct packed {
    logic manual_level;
    logic reset_level;
  } tick_t;

  typedef struct packed {
    logic       ring_hold;
    logic       ring_stop;
    logic       restart_request;
    logic       factory_reset_request;
    logic [7:0] press_count;
  } result_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] multi_press_window;
    logic [15:0] restart_hold_ticks;
    logic [15:0] factory_hold_ticks;
  } cfg_t;

  // debouncer view of the current tick
  typedef struct packed {
    logic accept;   // level has been quiet long enough
    logic level;    // raw level of this tick
    logic stable;   // accepted level before this tick
  } deb_t;

  typedef struct packed {
    logic       restart_request;
    logic       factory_reset_request;
    logic [7:0] press_count;
  } gesture_t;

endpackage

FILE: src/bgd_debounce.sv
// ---------------------------------------------------------------------------
// bgd_debounce
// Quiet-time debouncer for one active-low button level
// ---------------------------------------------------------------------------
module bgd_debounce (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          level,
  input  logic [7:0]    debounce_ticks,
  output bgd_pkg::deb_t status
);
  import bgd_pkg::*;

  logic       prev_level;
  logic [7:0] quiet_ticks;
  logic       stable_level;
  logic [7:0] quiet_ticks_next;

  always_comb begin
    if (level != prev_level) begin
      quiet_ticks_next = 8'd0;
    end else if (quiet_ticks != QUIET_MAX) begin
      quiet_ticks_next = quiet_ticks + 8'd1;
    end else begin
      quiet_ticks_next = quiet_ticks;
    end
  end

  assign status.accept = (quiet_ticks_next >= debounce_ticks);
  assign status.level  = level;
  assign status.stable = stable_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level   <= LEVEL_RELEASED;
      quiet_ticks  <= 8'd0;
      stable_level <= LEVEL_RELEASED;
    end else if (advance) begin
      prev_level  <= level;
      quiet_ticks <= quiet_ticks_next;
      if (status.accept) begin
        stable_level <= level;
      end
    end
  end

endmodule

FILE: src/bgd_press.sv
// ---------------------------------------------------------------------------
// bgd_press
// Press timers, press counter and hold checks of the reset button
// ---------------------------------------------------------------------------
module bgd_press (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  bgd_pkg::cfg_t     cfg,
  input  bgd_pkg::deb_t     deb,
  output bgd_pkg::gesture_t gesture
);
  import bgd_pkg::*;

  logic [15:0] ticks_since_press;
  logic [15:0] ticks_since_release;
  logic [7:0]  presses_counted;

  logic [15:0] press_inc;
  logic [15:0] release_inc;
  logic [15:0] ticks_since_press_next;
  logic [15:0] ticks_since_release_next;
  logic [7:0]  presses_counted_next;
  logic        press_edge;
  logic        release_edge;
  logic        held;

  assign press_inc   = (ticks_since_press != TIMER_MAX) ? ticks_since_press + 16'd1
                                                        : ticks_since_press;
  assign release_inc = (ticks_since_release != TIMER_MAX) ? ticks_since_release + 16'd1
                                                          : ticks_since_release;

  assign press_edge   = deb.accept && (deb.level == LEVEL_PRESSED)
                        && (deb.stable == LEVEL_RELEASED);
  assign release_edge = deb.accept && (deb.level == LEVEL_RELEASED)
                        && (deb.stable == LEVEL_PRESSED);
  assign held         = deb.accept && (deb.level == LEVEL_PRESSED)
                        && (deb.stable == LEVEL_PRESSED);

  always_comb begin
    presses_counted_next = presses_counted;
    if (press_edge) begin
      // a press after the window starts a new sequence
      if (release_inc > cfg.multi_press_window) begin
        presses_counted_next = 8'd1;
      end else if (presses_counted != COUNT_MAX) begin
        presses_counted_next = presses_counted + 8'd1;
      end
    end
  end

  assign ticks_since_press_next   = press_edge ? 16'd0 : press_inc;
  assign ticks_since_release_next = release_edge ? 16'd0 : release_inc;

  assign gesture.restart_request = held && (presses_counted == 8'd1)
                                   && (press_inc >= cfg.restart_hold_ticks);
  assign gesture.factory_reset_request = held && (presses_counted > 8'd1)
                                         && (press_inc >= cfg.factory_hold_ticks);
  assign gesture.press_count = presses_counted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_press   <= 16'd0;
      ticks_since_release <= 16'd0;
      presses_counted     <= 8'd0;
    end else if (advance) begin
      ticks_since_press   <= ticks_since_press_next;
      ticks_since_release <= ticks_since_release_next;
      presses_counted     <= presses_counted_next;
    end
  end

endmodule

FILE: src/button_gesture_detector.sv
// ---------------------------------------------------------------------------
// button_gesture_detector
// Debounces a manual and a reset button and reports ring and reset gestures
// ---------------------------------------------------------------------------
// Usage: send one request per millisecond tick on the tick channel (valid /
// stall), carrying both raw active-low levels. Each tick gives exactly one
// request on the result channel with the ring flags, the restart and
// factory reset flags and the current press count.
// A taken tick passes from the input register through the counter and
// compare logic into the result register, where result_valid shows it.
// Throughput: one tick per cycle while the result is not stalled; the debounce
// counters, press timers and press counter all update on each accepted tick.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more tick; tick_stall rises only while
// both registers are full and the result is stalled.
// Configuration: cfg_write with cfg_index and cfg_data, only while idle.
// Reset (rst, synchronous): both registers empty, levels released,
// counters and timers zero, configuration back to 50 / 1000 / 5000 / 10000.
// ---------------------------------------------------------------------------
module button_gesture_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  bgd_pkg::tick_t                      tick,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bgd_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [bgd_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data
);
  import bgd_pkg::*;

  cfg_t     cfg;
  logic     in_valid;
  tick_t    in_tick;
  logic     advance;
  logic     tick_take;
  deb_t     manual_deb;
  deb_t     reset_deb;
  gesture_t gesture;
  logic     ring_hold_next;
  logic     ring_stop_next;

  assign advance    = in_valid && (!result_valid || !result_stall);
  assign tick_stall = in_valid && result_valid && result_stall;
  assign tick_take  = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_TICKS_RESET;
      cfg.multi_press_window <= MULTI_PRESS_WINDOW_RESET;
      cfg.restart_hold_ticks <= RESTART_HOLD_TICKS_RESET;
      cfg.factory_hold_ticks <= FACTORY_HOLD_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE_TICKS:     cfg.debounce_ticks     <= cfg_data[7:0];
        CFG_MULTI_PRESS_WINDOW: cfg.multi_press_window <= cfg_data;
        CFG_RESTART_HOLD_TICKS: cfg.restart_hold_ticks <= cfg_data;
        CFG_FACTORY_HOLD_TICKS: cfg.factory_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      in_tick <= tick;
    end
  end

  bgd_debounce u_manual_deb (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .level          (in_tick.manual_level),
    .debounce_ticks (cfg.debounce_ticks),
    .status         (manual_deb)
  );

  bgd_debounce u_reset_deb (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .level          (in_tick.reset_level),
    .debounce_ticks (cfg.debounce_ticks),
    .status         (reset_deb)
  );

  bgd_press u_press (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .deb     (reset_deb),
    .gesture (gesture)
  );

  assign ring_hold_next = manual_deb.accept && (manual_deb.level == LEVEL_PRESSED);
  assign ring_stop_next = manual_deb.accept && (manual_deb.level == LEVEL_RELEASED)
                          && (manual_deb.stable == LEVEL_PRESSED);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.ring_hold             <= ring_hold_next;
      result.ring_stop             <= ring_stop_next;
      result.restart_request       <= gesture.restart_request;
      result.factory_reset_request <= gesture.factory_reset_request;
      result.press_count           <= gesture.press_count;
    end
  end

endmodule

FILE: src/bgd_checker.sv
// ---------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the button gesture detector results
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bgd_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input bgd_pkg::result_t result
);
  import bgd_pkg::*;

  `BGD_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `BGD_ASSERT_IMPL(a_ring_excl, result_valid, !(result.ring_hold && result.ring_stop), "ring hold and stop together")
  `BGD_ASSERT_IMPL(a_req_excl, result_valid, !(result.restart_request && result.factory_reset_request), "restart and factory reset together")
  `BGD_ASSERT_IMPL(a_restart_single, result_valid && result.restart_request, result.press_count == 8'd1, "restart without a single press")
  `BGD_ASSERT_IMPL(a_factory_multi, result_valid && result.factory_reset_request, result.press_count != 8'd0 && result.press_count != 8'd1, "factory reset without multi press")

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

FILE: verif/button_gesture_detector_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// button_gesture_detector_test
// Self-checking bench for the button gesture detector
// ---------------------------------------------------------------------------
// Feeds button level ticks through the valid / stall channel, keeps its own
// model of both debouncers, the press timers and the press counter, and
// compares every result request against the model in order. Runs short
// directed sequences, then random press / release patterns under several
// register settings, including the extremes, with random gaps and stalls.
// ---------------------------------------------------------------------------
module button_gesture_detector_test;
  import bgd_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   tick_valid;
  logic                   tick_stall;
  tick_t                  tick;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result;
  logic                   cfg_write;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [15:0]            cfg_data;

  button_gesture_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // gesture model state
  cfg_t        gesture_cfg;
  logic        man_prev;
  logic        man_stable;
  logic [7:0]  man_quiet;
  logic        rbtn_prev;
  logic        rbtn_stable;
  logic [7:0]  rbtn_quiet;
  logic [15:0] since_press;
  logic [15:0] since_release;
  logic [7:0]  presses;

  result_t pending_gestures[$];

  int mismatch_count;
  int ticks_sent;
  int results_seen;
  int settings_used;
  int send_idle_pct;
  int stall_pct;
  int holdoff_len;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  // one debouncer step, returns whether the level is accepted
  function automatic logic debounced(input logic lvl, inout logic prev,
                                     inout logic [7:0] quiet);
    if (lvl != prev) begin
      quiet = 8'd0;
    end else if (quiet != QUIET_MAX) begin
      quiet = quiet + 8'd1;
    end
    prev = lvl;
    return quiet >= gesture_cfg.debounce_ticks;
  endfunction

  function automatic result_t next_gesture(input tick_t t);
    result_t r;
    logic    man_ok;
    logic    rbtn_ok;
    r = '0;
    if (since_press != TIMER_MAX) since_press = since_press + 16'd1;
    if (since_release != TIMER_MAX) since_release = since_release + 16'd1;

    man_ok = debounced(t.manual_level, man_prev, man_quiet);
    if (man_ok) begin
      if (t.manual_level == LEVEL_PRESSED) begin
        r.ring_hold = 1'b1;
      end else if (man_stable == LEVEL_PRESSED) begin
        r.ring_stop = 1'b1;
      end
      man_stable = t.manual_level;
    end

    rbtn_ok = debounced(t.reset_level, rbtn_prev, rbtn_quiet);
    if (rbtn_ok) begin
      if (t.reset_level == LEVEL_PRESSED && rbtn_stable == LEVEL_RELEASED) begin
        if (since_release > gesture_cfg.multi_press_window) begin
          presses = 8'd1;
        end else if (presses != COUNT_MAX) begin
          presses = presses + 8'd1;
        end
        since_press = 16'd0;
      end else if (t.reset_level == LEVEL_RELEASED && rbtn_stable == LEVEL_PRESSED) begin
        since_release = 16'd0;
      end else if (t.reset_level == LEVEL_PRESSED && rbtn_stable == LEVEL_PRESSED) begin
        if (presses == 8'd1 && since_press >= gesture_cfg.restart_hold_ticks) begin
          r.restart_request = 1'b1;
        end else if (presses >= 8'd2 && since_press >= gesture_cfg.factory_hold_ticks) begin
          r.factory_reset_request = 1'b1;
        end
      end
      rbtn_stable = t.reset_level;
    end
    r.press_count = presses;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_gestures.size() == 0) begin
        report_mismatch($sformatf("unexpected result hold %b stop %b count %0d",
                                  result.ring_hold, result.ring_stop, result.press_count));
      end else begin
        want = pending_gestures.pop_front();
        if (result.ring_hold !== want.ring_hold || result.ring_stop !== want.ring_stop ||
            result.restart_request !== want.restart_request ||
            result.factory_reset_request !== want.factory_reset_request ||
            result.press_count !== want.press_count) begin
          report_mismatch($sformatf(
            "result %0d expected hold %b stop %b restart %b factory %b count %0d, got %b %b %b %b %0d",
            results_seen, want.ring_hold, want.ring_stop, want.restart_request,
            want.factory_reset_request, want.press_count, result.ring_hold, result.ring_stop,
            result.restart_request, result.factory_reset_request, result.press_count));
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_len > 0) begin
        n = holdoff_len;
        holdoff_len = 0;
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_tick(input tick_t t);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    do @(posedge clk); while (tick_stall);
    pending_gestures.push_back(next_gesture(t));
    ticks_sent++;
  endtask

  // stop sending and let every outstanding request come back
  task automatic drain();
    int waited;
    waited = 0;
    tick_valid <= 1'b0;
    while (pending_gestures.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_DEBOUNCE_TICKS:     gesture_cfg.debounce_ticks     = val[7:0];
      CFG_MULTI_PRESS_WINDOW: gesture_cfg.multi_press_window = val;
      CFG_RESTART_HOLD_TICKS: gesture_cfg.restart_hold_ticks = val;
      CFG_FACTORY_HOLD_TICKS: gesture_cfg.factory_hold_ticks = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] deb, input logic [15:0] win,
                           input logic [15:0] restart_hold, input logic [15:0] factory_hold);
    drain();
    write_reg(CFG_DEBOUNCE_TICKS, {8'd0, deb});
    write_reg(CFG_MULTI_PRESS_WINDOW, win);
    write_reg(CFG_RESTART_HOLD_TICKS, restart_hold);
    write_reg(CFG_FACTORY_HOLD_TICKS, factory_hold);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic hold_levels(input logic man, input logic rbtn, input int n);
    tick_t t;
    t.manual_level = man;
    t.reset_level  = rbtn;
    repeat (n) send_tick(t);
  endtask

  function automatic int run_length(input int min_run, input int max_run, input int bounce_pct);
    if ($urandom_range(99) < bounce_pct) return $urandom_range(1, 2);
    return $urandom_range(min_run, max_run);
  endfunction

  // both buttons toggle independently; short runs act as contact bounce
  task automatic drive_buttons(input int n, input int min_run, input int max_run,
                               input int bounce_pct);
    tick_t t;
    int    man_left;
    int    rbtn_left;
    t.manual_level = 1'($urandom_range(1));
    t.reset_level  = 1'($urandom_range(1));
    man_left  = run_length(min_run, max_run, bounce_pct);
    rbtn_left = run_length(min_run, max_run, bounce_pct);
    repeat (n) begin
      if (man_left == 0) begin
        t.manual_level = ~t.manual_level;
        man_left = run_length(min_run, max_run, bounce_pct);
      end
      if (rbtn_left == 0) begin
        t.reset_level = ~t.reset_level;
        rbtn_left = run_length(min_run, max_run, bounce_pct);
      end
      send_tick(t);
      man_left--;
      rbtn_left--;
    end
  endtask

  // default settings: nothing settles within a few ticks
  task automatic test_reset_state();
    hold_levels(LEVEL_RELEASED, LEVEL_RELEASED, 2);
    hold_levels(LEVEL_PRESSED, LEVEL_PRESSED, 2);
    hold_levels(LEVEL_PRESSED, LEVEL_RELEASED, 2);
    hold_levels(LEVEL_RELEASED, LEVEL_PRESSED, 2);
  endtask

  task automatic test_directed_gestures();
    configure(8'd1, 16'd3, 16'd2, 16'd3);
    hold_levels(LEVEL_PRESSED, LEVEL_RELEASED, 4);   // ring hold
    hold_levels(LEVEL_RELEASED, LEVEL_RELEASED, 3);  // ring stop
    hold_levels(LEVEL_RELEASED, LEVEL_PRESSED, 5);   // single press, restart
    hold_levels(LEVEL_RELEASED, LEVEL_RELEASED, 2);
    hold_levels(LEVEL_PRESSED, LEVEL_PRESSED, 6);    // second press, factory
    hold_levels(LEVEL_RELEASED, LEVEL_RELEASED, 6);  // window runs out
    hold_levels(LEVEL_RELEASED, LEVEL_PRESSED, 2);   // fresh count
    hold_levels(LEVEL_PRESSED, LEVEL_RELEASED, 1);   // bounce
  endtask

  task automatic test_zero_thresholds();
    configure(8'd0, 16'd0, 16'd0, 16'd0);
    drive_buttons(100, 1, 8, 20);
  endtask

  task automatic test_mid_settings();
    configure(8'd3, 16'd12, 16'd6, 16'd9);
    holdoff_len = 150;
    drive_buttons(200, 4, 14, 25);
  endtask

  task automatic test_long_debounce();
    configure(8'd255, 16'd65534, 16'd1, 16'd2);
    drive_buttons(300, 256, 290, 5);
  endtask

  task automatic test_max_thresholds();
    configure(8'd1, 16'd65535, 16'd65535, 16'd65535);
    drive_buttons(60, 2, 6, 20);
  endtask

  // back-to-back presses with no gaps or stalls push the count to its ceiling
  task automatic test_press_count_saturation();
    send_idle_pct = 0;
    stall_pct     = 0;
    configure(8'd0, 16'd65535, 16'd65535, 16'd3);
    drive_buttons(560, 1, 1, 0);
    hold_levels(LEVEL_RELEASED, LEVEL_PRESSED, 6);
    drain();
    send_idle_pct = 30;
    stall_pct     = 30;
  endtask

  initial begin
    int fail_count;
    rst            = 1'b1;
    tick_valid     = 1'b0;
    tick           = '{manual_level: LEVEL_RELEASED, reset_level: LEVEL_RELEASED};
    cfg_write      = 1'b0;
    cfg_index      = CFG_DEBOUNCE_TICKS;
    cfg_data       = 16'd0;
    send_idle_pct  = 30;
    stall_pct      = 30;
    holdoff_len    = 0;
    mismatch_count = 0;
    ticks_sent     = 0;
    results_seen   = 0;
    settings_used  = 0;
    gesture_cfg    = '{DEBOUNCE_TICKS_RESET, MULTI_PRESS_WINDOW_RESET,
                       RESTART_HOLD_TICKS_RESET, FACTORY_HOLD_TICKS_RESET};
    man_prev       = LEVEL_RELEASED;
    man_stable     = LEVEL_RELEASED;
    man_quiet      = 8'd0;
    rbtn_prev      = LEVEL_RELEASED;
    rbtn_stable    = LEVEL_RELEASED;
    rbtn_quiet     = 8'd0;
    since_press    = 16'd0;
    since_release  = 16'd0;
    presses        = 8'd0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_gestures();
    test_zero_thresholds();
    test_mid_settings();
    test_long_debounce();
    test_max_thresholds();
    test_press_count_saturation();

    drain();
    fail_count = mismatch_count + pending_gestures.size();
    if (pending_gestures.size() != 0) begin
      $display("%0d results never arrived", pending_gestures.size());
    end
    $display("sent %0d button ticks under %0d register settings, checked %0d results",
             ticks_sent, settings_used, results_seen);
    $display("%0d mismatches", mismatch_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
